// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ERR_W  = 2;

  localparam int unsigned IN_DATA_W  = ((WORD_W + 7) / 8) * 8;
  localparam int unsigned IN_USER_W  = FUNC_W;
  localparam int unsigned OUT_DATA_W = ((WORD_W + CNT_W + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W = 1 + ERR_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

endpackage

// ===== rtl/bdq_ram.sv =====
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bounded_deque_unit.sv =====
// Bounded double-ended queue of signed 32-bit words held in a circular buffer.
// A push or a failed pop shows its result in the cycle after acceptance; a successful
// pop passes the registered RAM read, then the output register, and no new request
// is taken meanwhile. Pushes and failed pops run one per cycle unless the output stalls.
// Reset (rst_ni low, asynchronous): the deque is empty, the front pointer is zero
// and no result is pending; the word storage itself is not cleared.
module bounded_deque_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request channel.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bdq_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // push_value[31:0]
  input  logic [bdq_pkg::IN_USER_W-1:0]   s_axis_tuser,  // func[1:0]
  // Result channel.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bdq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // pop_value, occupancy, zero pad
  output logic [bdq_pkg::OUT_USER_W-1:0]  m_axis_tuser   // pop_valid, error_code[1:0]
);

  import bdq_pkg::*;

  // The block is either ready for a request or waiting for the RAM read of a pop.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic             state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Output register, which parts the request side from the result side.
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_value_q, out_value_d;
  logic              out_pvalid_q, out_pvalid_d;
  err_e              out_err_q, out_err_d;
  logic [CNT_W-1:0]  out_occ_q, out_occ_d;

  logic              in_xact;
  func_e             func;
  logic [WORD_W-1:0] push_word;
  logic              is_full, is_empty;

  logic [IDX_W-1:0]  front_dec, front_inc;
  logic [SUM_W-1:0]  back_sum, last_sum;
  logic [IDX_W-1:0]  back_idx, last_idx;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  assign func      = func_e'(s_axis_tuser[FUNC_W-1:0]);
  assign push_word = s_axis_tdata[WORD_W-1:0];
  assign is_full   = (count_q == CNT_W'(DEPTH));
  assign is_empty  = (count_q == '0);

  // A new request is taken only when the output register will be free for its result.
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_xact       = s_axis_tvalid && s_axis_tready;

  // Pointer arithmetic wraps by compare, so any depth works, not just powers of two.
  assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
  assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
  assign back_sum  = SUM_W'(front_q) + SUM_W'(count_q);
  assign back_idx  = (back_sum >= DEPTH_S) ? IDX_W'(back_sum - DEPTH_S) : IDX_W'(back_sum);
  assign last_sum  = back_sum - 1'b1;
  assign last_idx  = (last_sum >= DEPTH_S) ? IDX_W'(last_sum - DEPTH_S) : IDX_W'(last_sum);

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_pvalid_d = out_pvalid_q;
    out_err_d    = out_err_q;
    out_occ_d    = out_occ_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = back_idx;
    ram_raddr    = front_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xact) begin
          out_value_d  = '0;
          out_pvalid_d = 1'b0;
          out_err_d    = ERR_OK;
          case (func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                out_err_d = ERR_FULL;
                out_occ_d = count_q;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = (func == FUNC_PUSH_FRONT) ? front_dec : back_idx;
                if (func == FUNC_PUSH_FRONT) begin
                  front_d = front_dec;
                end
                count_d   = count_q + 1'b1;
                out_occ_d = count_q + 1'b1;
              end
            end
            default: begin
              if (is_empty) begin
                out_valid_d = 1'b1;
                out_err_d   = ERR_EMPTY;
                out_occ_d   = count_q;
              end else begin
                // The word arrives from the RAM in the next cycle.
                ram_re    = 1'b1;
                ram_raddr = (func == FUNC_POP_FRONT) ? front_q : last_idx;
                if (func == FUNC_POP_FRONT) begin
                  front_d = front_inc;
                end
                count_d   = count_q - 1'b1;
                out_occ_d = count_q - 1'b1;
                state_d   = ST_READ;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_d  = 1'b1;
        out_value_d  = ram_rdata;
        out_pvalid_d = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_pvalid_q <= out_pvalid_d;
    out_err_q    <= out_err_d;
    out_occ_q    <= out_occ_d;
  end

  bdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (push_word),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_occ_q, out_value_q});
  assign m_axis_tuser  = {out_err_q, out_pvalid_q};

`ifndef SYNTHESIS
  // The stored count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_W'(DEPTH))
    else $error("stored count exceeds capacity");

  // While a pop waits for its word, the output register is empty and no request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_READ) |-> (!out_valid_q && !s_axis_tready))
    else $error("pop read overlaps a pending result or a new request");

  // A successful pop is followed by the read state and then a valid popped word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_READ) |=> (out_valid_q && out_pvalid_q && out_err_q == ERR_OK))
    else $error("pop result not delivered after the read");
`endif

endmodule
